[rtl/core/dmhts_pkg.sv]
package dmhts_pkg;

	// Slot count; a power of two, so the slot index is the low key bits.
	localparam int unsigned ENTRIES = 4096;
	localparam int unsigned IDX_W   = $clog2(ENTRIES);

	localparam int unsigned KEY_W  = 64;
	localparam int unsigned PRIO_W = 8;
	localparam int unsigned PAY_W  = 64;
	localparam int unsigned CNT_W  = 32;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
	localparam logic [CNT_W-1:0] CNT_MAX  = '1;

	localparam logic [1:0] OP_LOOKUP = 2'd0;
	localparam logic [1:0] OP_STORE  = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;
	localparam logic [1:0] OP_NOP    = 2'd3;

	typedef struct packed {
		logic [1:0]        operation;
		logic [KEY_W-1:0]  lookup_key;
		logic [PRIO_W-1:0] entry_priority;
		logic [PAY_W-1:0]  entry_payload;
	} req_t;

	typedef struct packed {
		logic              found;
		logic [PRIO_W-1:0] found_priority;
		logic [PAY_W-1:0]  found_payload;
		logic              store_ok;
		logic [CNT_W-1:0]  hit_count;
		logic [CNT_W-1:0]  occupied_count;
		logic [CNT_W-1:0]  collision_count;
	} rsp_t;

	typedef struct packed {
		logic              valid;
		logic [KEY_W-1:0]  key;
		logic [PRIO_W-1:0] prio;
		logic [PAY_W-1:0]  payload;
	} slot_t;

	localparam int unsigned SLOT_W = $bits(slot_t);

	typedef enum logic [1:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_ACCESS
	} state_t;

	typedef struct packed {
		logic             busy;
		logic             accept;
		logic             access;
		logic             sweep_we;
		logic [IDX_W-1:0] sweep_idx;
	} ctrl_t;

	// Saturating increment.
	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c, input logic en);
		return (en && (c != CNT_MAX)) ? c + 1'b1 : c;
	endfunction

endpackage

[rtl/core/dmhts_ram.sv]
module dmhts_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/dmhts_ctrl.sv]
module dmhts_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [1:0]      operation,
	output dmhts_pkg::ctrl_t ctrl
);
	import dmhts_pkg::*;

	state_t           state_q, state_nxt;
	logic [IDX_W-1:0] sweep_q;
	logic             accept;

	assign accept = start && (state_q == ST_IDLE);

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_SWEEP: begin
				if (sweep_q == LAST_IDX) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					priority if (operation == OP_LOOKUP || operation == OP_STORE) begin
						state_nxt = ST_ACCESS;
					end else if (operation == OP_CLEAR) begin
						state_nxt = ST_SWEEP;
					end else begin
						state_nxt = ST_IDLE;
					end
				end
			end
			ST_ACCESS: state_nxt = ST_IDLE;
			default:   state_nxt = ST_SWEEP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
			sweep_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (accept && operation == OP_CLEAR) begin
				sweep_q <= '0;
			end else if (state_q == ST_SWEEP) begin
				sweep_q <= sweep_q + 1'b1;
			end
		end
	end

	// Outputs.
	always_comb begin
		ctrl.busy      = (state_q != ST_IDLE);
		ctrl.accept    = accept;
		ctrl.access    = (state_q == ST_ACCESS);
		ctrl.sweep_we  = (state_q == ST_SWEEP);
		ctrl.sweep_idx = sweep_q;
	end

endmodule

[rtl/core/direct_mapped_hash_table_store.sv]
// Direct-mapped record table. A transfer is taken on a rising edge with start high and busy
// low. For lookup and store the slot addressed by the low key bits is read from the single
// table memory, then compared and written back, and the result is then registered and shows
// with done high for exactly one cycle; busy is high during the compare step, so a new
// transfer is taken only once that step of the previous one is done.
// Clear and no-operation answer on the next cycle. The receiver cannot stall: catch the
// result in the cycle that done is high. After reset and after every clear the block
// zeroes all ENTRIES (4096) slots, one slot a cycle, busy until the last one is written.
module direct_mapped_hash_table_store (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  dmhts_pkg::req_t request,
	output logic            busy,
	output logic            done,
	output dmhts_pkg::rsp_t result
);
	import dmhts_pkg::*;

	ctrl_t            ctrl;
	req_t             req_s1;
	slot_t            rd_slot;
	logic [SLOT_W-1:0] rd_bits;
	slot_t            wr_slot;
	logic [IDX_W-1:0] idx_s1;
	logic [IDX_W-1:0] waddr;
	logic             we;

	logic             key_eq, hit, is_store, do_write;
	logic [CNT_W-1:0] hits_q, filled_q, coll_q;
	logic [CNT_W-1:0] hits_nxt, filled_nxt, coll_nxt;
	logic             done_q;
	rsp_t             result_q;

	dmhts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (request.operation),
		.ctrl      (ctrl)
	);

	// Hold the request while its slot is read.
	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			req_s1 <= request;
		end
	end

	assign idx_s1 = req_s1.lookup_key[IDX_W-1:0];

	// Compare the slot just read against the held request.
	assign rd_slot  = slot_t'(rd_bits);
	assign key_eq   = (rd_slot.key == req_s1.lookup_key);
	assign hit      = rd_slot.valid && key_eq;
	assign is_store = (req_s1.operation == OP_STORE);
	assign do_write = is_store && (req_s1.entry_priority >= rd_slot.prio);

	assign hits_nxt   = sat_inc(hits_q, !is_store && hit);
	assign filled_nxt = sat_inc(filled_q, do_write && !rd_slot.valid);
	assign coll_nxt   = sat_inc(coll_q, do_write && rd_slot.valid && !key_eq);

	// Write back the new record, or zero one slot per cycle while sweeping.
	always_comb begin
		wr_slot.valid   = 1'b1;
		wr_slot.key     = req_s1.lookup_key;
		wr_slot.prio    = req_s1.entry_priority;
		wr_slot.payload = req_s1.entry_payload;
		if (ctrl.sweep_we) begin
			wr_slot = '0;
		end
	end

	assign we    = ctrl.sweep_we || (ctrl.access && do_write);
	assign waddr = ctrl.sweep_we ? ctrl.sweep_idx : idx_s1;

	dmhts_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (ENTRIES)
	) u_table (
		.clk   (clk),
		.re    (ctrl.accept),
		.raddr (request.lookup_key[IDX_W-1:0]),
		.rdata (rd_bits),
		.we    (we),
		.waddr (waddr),
		.wdata (wr_slot)
	);

	// Counters: zero on clear, update after each lookup or store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q   <= '0;
			filled_q <= '0;
			coll_q   <= '0;
		end else if (ctrl.accept && request.operation == OP_CLEAR) begin
			hits_q   <= '0;
			filled_q <= '0;
			coll_q   <= '0;
		end else if (ctrl.access) begin
			hits_q   <= hits_nxt;
			filled_q <= filled_nxt;
			coll_q   <= coll_nxt;
		end
	end

	// Result register: pulse done for one cycle per transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctrl.access || (ctrl.accept &&
				(request.operation == OP_CLEAR || request.operation == OP_NOP));
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.access) begin
			result_q.found           <= !is_store && hit;
			result_q.found_priority  <= rd_slot.prio;
			result_q.found_payload   <= rd_slot.payload;
			result_q.store_ok        <= do_write && (!rd_slot.valid || key_eq);
			result_q.hit_count       <= hits_nxt;
			result_q.occupied_count  <= filled_nxt;
			result_q.collision_count <= coll_nxt;
		end else if (ctrl.accept) begin
			result_q.found          <= 1'b0;
			result_q.found_priority <= '0;
			result_q.found_payload  <= '0;
			result_q.store_ok       <= 1'b0;
			if (request.operation == OP_CLEAR) begin
				result_q.hit_count       <= '0;
				result_q.occupied_count  <= '0;
				result_q.collision_count <= '0;
			end else begin
				result_q.hit_count       <= hits_q;
				result_q.occupied_count  <= filled_q;
				result_q.collision_count <= coll_q;
			end
		end
	end

	assign busy   = ctrl.busy;
	assign done   = done_q;
	assign result = result_q;

endmodule

[sim/direct_mapped_hash_table_store_tb.sv]
module direct_mapped_hash_table_store_tb;
	import dmhts_pkg::*;

	// Keys that share one slot (low index bits 12'h5A5) but differ above it.
	localparam logic [KEY_W-1:0] KEY_A = 64'h0123_4567_89AB_C5A5;
	localparam logic [KEY_W-1:0] KEY_B = 64'hFEDC_BA98_7654_35A5;
	localparam int unsigned RANDOM_ITEMS = 1150;
	localparam int unsigned DRAIN_LIMIT  = 1000;

	logic clk;
	logic arst_n;
	logic start;
	req_t request;
	logic busy;
	logic done;
	rsp_t result;

	// Shadow copy of the table and its counters, advanced at every accepted transfer.
	slot_t            shadow_slots [ENTRIES];
	logic [CNT_W-1:0] shadow_hits;
	logic [CNT_W-1:0] shadow_filled;
	logic [CNT_W-1:0] shadow_overwrites;

	// Answers still owed by the block, oldest first.
	rsp_t        pending_answers [$];
	int unsigned mismatch_count;
	logic        back_to_back;
	logic [KEY_W-1:IDX_W] key_tags [4];

	direct_mapped_hash_table_store u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.request (request),
		.busy    (busy),
		.done    (done),
		.result  (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Bound the run; a hung handshake ends here.
	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

	function automatic logic [CNT_W-1:0] bump_saturating(input logic [CNT_W-1:0] c);
		return (c == '1) ? c : c + 1'b1;
	endfunction

	// Empty the shadow table and zero the counters, as reset and clear do.
	function automatic void wipe_shadow();
		foreach (shadow_slots[i])
			shadow_slots[i] = '0;
		shadow_hits       = '0;
		shadow_filled     = '0;
		shadow_overwrites = '0;
	endfunction

	// Apply one transfer to the shadow table and return the answer the block owes for it.
	function automatic rsp_t shadow_access(input req_t r);
		rsp_t             ans = '0;
		logic [IDX_W-1:0] idx;
		slot_t            old;

		idx = r.lookup_key[IDX_W-1:0];
		old = shadow_slots[idx];
		case (r.operation)
			OP_LOOKUP, OP_STORE: begin
				// Report the record held before the operation, valid or not.
				ans.found_priority = old.prio;
				ans.found_payload  = old.payload;
				if (r.operation == OP_LOOKUP) begin
					if (old.valid && old.key == r.lookup_key) begin
						ans.found   = 1'b1;
						shadow_hits = bump_saturating(shadow_hits);
					end
				end else if (r.entry_priority >= old.prio) begin
					shadow_slots[idx] = '{valid: 1'b1, key: r.lookup_key,
						prio: r.entry_priority, payload: r.entry_payload};
					if (!old.valid) begin
						shadow_filled = bump_saturating(shadow_filled);
						ans.store_ok  = 1'b1;
					end else if (old.key != r.lookup_key) begin
						// Different key evicted: count it and report failure.
						shadow_overwrites = bump_saturating(shadow_overwrites);
					end else begin
						ans.store_ok = 1'b1;
					end
				end
			end
			OP_CLEAR: wipe_shadow();
			default: ;
		endcase
		ans.hit_count       = shadow_hits;
		ans.occupied_count  = shadow_filled;
		ans.collision_count = shadow_overwrites;
		return ans;
	endfunction

	function automatic req_t make_request(input logic [1:0] op, input logic [KEY_W-1:0] key,
			input logic [PRIO_W-1:0] prio, input logic [PAY_W-1:0] payload);
		req_t r;
		r.operation      = op;
		r.lookup_key     = key;
		r.entry_priority = prio;
		r.entry_payload  = payload;
		return r;
	endfunction

	// Present one transfer from the current rising edge, hold it until busy is seen low at
	// an edge, then record its answer. Lower start only when a gap follows, so a
	// back-to-back transfer keeps start high without a second assignment in the same step.
	task automatic issue_request(input req_t r);
		int unsigned gap;
		request <= r;
		start   <= 1'b1;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		pending_answers.push_back(shadow_access(r));
		gap = back_to_back ? 0 : $urandom_range(0, 17);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic note_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, want, got);
	endtask

	// Take each result in the cycle that done is high and compare it with the oldest
	// outstanding answer, field by field.
	always @(posedge clk) begin
		rsp_t want;
		if (done === 1'b1) begin
			if (pending_answers.size() == 0) begin
				note_mismatch("unexpected result", 64'd0, 64'd1);
			end else begin
				want = pending_answers.pop_front();
				if (result.found !== want.found)
					note_mismatch("found", 64'(want.found), 64'(result.found));
				if (result.found_priority !== want.found_priority)
					note_mismatch("found_priority", 64'(want.found_priority),
						64'(result.found_priority));
				if (result.found_payload !== want.found_payload)
					note_mismatch("found_payload", want.found_payload, result.found_payload);
				if (result.store_ok !== want.store_ok)
					note_mismatch("store_ok", 64'(want.store_ok), 64'(result.store_ok));
				if (result.hit_count !== want.hit_count)
					note_mismatch("hit_count", 64'(want.hit_count), 64'(result.hit_count));
				if (result.occupied_count !== want.occupied_count)
					note_mismatch("occupied_count", 64'(want.occupied_count),
						64'(result.occupied_count));
				if (result.collision_count !== want.collision_count)
					note_mismatch("collision_count", 64'(want.collision_count),
						64'(result.collision_count));
			end
		end
	end

	// Empty slots: key zero and the all-ones key both miss, then fill the top slot at the
	// lowest priority and read it back.
	task automatic test_empty_slots();
		issue_request(make_request(OP_LOOKUP, '0, '0, '0));
		issue_request(make_request(OP_LOOKUP, '1, '1, '1));
		issue_request(make_request(OP_NOP, '1, '1, '1));
		issue_request(make_request(OP_STORE, '1, '0, '1));
		issue_request(make_request(OP_LOOKUP, '1, '0, '0));
	endtask

	// Replacement rules on one slot: equal priority replaces, lower priority is dropped for
	// the same and for a different key, higher priority evicts a different key.
	task automatic test_replacement_rules();
		issue_request(make_request(OP_STORE, KEY_A, 8'd8, 64'h1111_2222_3333_4444));
		issue_request(make_request(OP_LOOKUP, KEY_A, '0, '0));
		issue_request(make_request(OP_LOOKUP, KEY_B, '0, '0));
		issue_request(make_request(OP_STORE, KEY_A, 8'd8, 64'h5555_6666_7777_8888));
		issue_request(make_request(OP_STORE, KEY_A, 8'd7, 64'hDEAD_BEEF_0000_0001));
		issue_request(make_request(OP_STORE, KEY_B, 8'd7, 64'hDEAD_BEEF_0000_0002));
		issue_request(make_request(OP_STORE, KEY_B, 8'hFF, 64'hAAAA_5555_AAAA_5555));
		issue_request(make_request(OP_LOOKUP, KEY_A, '0, '0));
		issue_request(make_request(OP_LOOKUP, KEY_B, '0, '0));
	endtask

	// Key zero is an ordinary key once stored; a key aliasing slot zero evicts it.
	task automatic test_key_zero();
		issue_request(make_request(OP_STORE, '0, 8'hFF, '0));
		issue_request(make_request(OP_LOOKUP, '0, '0, '0));
		issue_request(make_request(OP_STORE, 64'h0000_0000_0000_1000, 8'hFF, '1));
	endtask

	// Clear with every other field set: table and counters go back to empty.
	task automatic test_clear();
		issue_request(make_request(OP_CLEAR, '1, '1, '1));
		issue_request(make_request(OP_LOOKUP, KEY_B, '0, '0));
		issue_request(make_request(OP_LOOKUP, '1, '0, '0));
	endtask

	function automatic req_t random_request();
		req_t        r;
		int unsigned roll;

		r.entry_payload = {$urandom, $urandom};
		// Keep most keys on sixteen slots spread from index zero to the last one, with four
		// tags above the index, so lookups hit and stores collide often.
		if ($urandom_range(0, 99) < 85)
			r.lookup_key = {key_tags[$urandom_range(0, 3)], IDX_W'($urandom_range(0, 15) * 273)};
		else
			r.lookup_key = {$urandom, $urandom};
		r.entry_priority = ($urandom_range(0, 9) == 0) ? PRIO_W'($urandom_range(0, 255))
			: PRIO_W'($urandom_range(0, 3));
		roll = $urandom_range(0, 999);
		if (roll < 470)
			r.operation = OP_LOOKUP;
		else if (roll < 955)
			r.operation = OP_STORE;
		else if (roll < 960)
			r.operation = OP_CLEAR;
		else
			r.operation = OP_NOP;
		return r;
	endfunction

	// Random traffic; every 64 items choose afresh between idling gaps and back-to-back transfers.
	task automatic test_random_traffic(input int unsigned count);
		key_tags[0] = '0;
		key_tags[1] = '1;
		key_tags[2] = (KEY_W-IDX_W)'({$urandom, $urandom});
		key_tags[3] = (KEY_W-IDX_W)'({$urandom, $urandom});
		for (int unsigned i = 0; i < count; i++) begin
			if (i % 64 == 0)
				back_to_back = ($urandom_range(0, 3) == 0);
			issue_request(random_request());
		end
		back_to_back = 1'b0;
	endtask

	initial begin
		int unsigned guard;

		arst_n  <= 1'b0;
		start   <= 1'b0;
		request <= '0;
		mismatch_count = 0;
		back_to_back   = 1'b0;
		wipe_shadow();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_slots();
		test_replacement_rules();
		test_key_zero();
		test_clear();
		test_random_traffic(RANDOM_ITEMS);

		// Drop start, wait for every outstanding answer, then let the pipeline settle.
		start <= 1'b0;
		guard = 0;
		while (pending_answers.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);

		if (mismatch_count == 0 && pending_answers.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
